>>> src/mmc1m_pkg.sv
// Shared types and constants for the serial bank-switch mapper.
`default_nettype none
package mmc1m_pkg;

  // Access kinds carried on the slave tuser field; code 7 is unused
  typedef enum logic [2:0] {
    OP_REG_WR  = 3'd0,
    OP_PRG_RD  = 3'd1,
    OP_CHR_RD  = 3'd2,
    OP_CHR_WR  = 3'd3,
    OP_NT      = 3'd4,
    OP_RAM_RD  = 3'd5,
    OP_RAM_WR  = 3'd6
  } op_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_PRG_LOG2 = 2'd0;
  localparam logic [1:0] CFG_CHR_LOG2 = 2'd1;
  localparam logic [1:0] CFG_CHR_RAM  = 2'd2;

  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 8;
  localparam int MAP_W    = 18;
  localparam int CFG_W    = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [4:0] SHIFT_RESET    = 5'h10;
  localparam logic [4:0] CTRL_RESET     = 5'h0C;
  localparam logic [4:0] PRG_LOG2_RESET = 5'd15;
  localparam logic [4:0] CHR_LOG2_RESET = 5'd13;
  localparam logic [4:0] PRG_LOG2_MIN   = 5'd14;
  localparam logic [4:0] PRG_LOG2_MAX   = 5'd18;
  localparam logic [4:0] CHR_LOG2_MIN   = 5'd13;
  localparam logic [4:0] CHR_LOG2_MAX   = 5'd17;

  // Bank registers and configuration seen by the translator
  typedef struct packed {
    logic [4:0] control;
    logic [4:0] chr_lo;
    logic [4:0] chr_hi;
    logic [4:0] prg;
    logic [4:0] prg_log2;
    logic [4:0] chr_log2;
    logic       chr_is_ram;
  } map_state_t;

  typedef struct packed {
    logic             read_all_ones;
    logic             mem_enable;
    logic [MAP_W-1:0] mapped_addr;
  } map_result_t;

endpackage
`default_nettype wire

>>> src/mmc1m_ctrl.sv
// Serial shift loader, bank registers and configuration registers.
`default_nettype none
module mmc1m_ctrl (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [mmc1m_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mmc1m_pkg::CFG_W-1:0]          cfg_data,
  input  wire logic                                 reg_wr,
  input  wire logic [mmc1m_pkg::ADDR_W-1:0]         addr,
  input  wire logic [mmc1m_pkg::DATA_W-1:0]         data,
  output mmc1m_pkg::map_state_t                     state
);

  logic [4:0] shift;
  logic [4:0] shift_next;
  logic [4:0] control;
  logic [4:0] control_next;
  logic [4:0] chr_lo;
  logic [4:0] chr_lo_next;
  logic [4:0] chr_hi;
  logic [4:0] chr_hi_next;
  logic [4:0] prg;
  logic [4:0] prg_next;
  logic [4:0] prg_log2;
  logic [4:0] chr_log2;
  logic       chr_is_ram;
  logic [4:0] shifted;
  logic       load;

  assign load    = reg_wr && addr[15];
  assign shifted = {data[0], shift[4:1]};

  always_comb begin
    shift_next   = shift;
    control_next = control;
    chr_lo_next  = chr_lo;
    chr_hi_next  = chr_hi;
    prg_next     = prg;
    if (load) begin
      if (data[7]) begin
        shift_next   = mmc1m_pkg::SHIFT_RESET;
        control_next = control | mmc1m_pkg::CTRL_RESET;
      end else if (shift[0]) begin
        // marker reached bit 0: fifth bit, commit by address bits 14:13
        shift_next = mmc1m_pkg::SHIFT_RESET;
        unique case (addr[14:13])
          2'd0:    control_next = shifted;
          2'd1:    chr_lo_next  = shifted;
          2'd2:    chr_hi_next  = shifted;
          default: prg_next     = shifted;
        endcase
      end else begin
        shift_next = shifted;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift   <= mmc1m_pkg::SHIFT_RESET;
      control <= mmc1m_pkg::CTRL_RESET;
      chr_lo  <= '0;
      chr_hi  <= '0;
      prg     <= '0;
    end else begin
      shift   <= shift_next;
      control <= control_next;
      chr_lo  <= chr_lo_next;
      chr_hi  <= chr_hi_next;
      prg     <= prg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_log2   <= mmc1m_pkg::PRG_LOG2_RESET;
      chr_log2   <= mmc1m_pkg::CHR_LOG2_RESET;
      chr_is_ram <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mmc1m_pkg::CFG_PRG_LOG2: prg_log2   <= cfg_data;
        mmc1m_pkg::CFG_CHR_LOG2: chr_log2   <= cfg_data;
        mmc1m_pkg::CFG_CHR_RAM:  chr_is_ram <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign state = '{control:    control,
                   chr_lo:     chr_lo,
                   chr_hi:     chr_hi,
                   prg:        prg,
                   prg_log2:   prg_log2,
                   chr_log2:   chr_log2,
                   chr_is_ram: chr_is_ram};

  // the marker bit keeps the shifter from ever reading all zeros
  a_shift_nonzero: assert property (@(posedge clk) disable iff (rst) shift != 5'd0)
    else $error("serial shifter lost its marker bit");

  a_reset_bit: assert property (@(posedge clk) disable iff (rst)
    (load && data[7]) |=> (shift == mmc1m_pkg::SHIFT_RESET && control[3:2] == 2'b11))
    else $error("reset bit did not restore shifter and fixed-last mode");

  a_low_write_ignored: assert property (@(posedge clk) disable iff (rst)
    (reg_wr && !addr[15]) |=> $stable(shift) && $stable(control) && $stable(prg))
    else $error("register write below 0x8000 changed mapper state");

endmodule
`default_nettype wire

>>> src/mmc1m_xlate.sv
// Address translation for program, pattern, nametable and work RAM accesses.
`default_nettype none
module mmc1m_xlate (
  input  wire logic [2:0]                    op,
  input  wire logic [mmc1m_pkg::ADDR_W-1:0]  addr,
  input  wire mmc1m_pkg::map_state_t         state,
  output mmc1m_pkg::map_result_t             result
);

  localparam int MW = mmc1m_pkg::MAP_W;

  logic [4:0]    prg_c;
  logic [4:0]    chr_c;
  logic [MW:0]   prg_size;
  logic [MW-1:0] prg_mask;
  logic [MW-1:0] prg_last;
  logic [MW-1:0] chr_mask;
  logic [1:0]    prg_mode;
  logic [3:0]    bank;
  logic [MW-1:0] prg_raw;
  logic [MW-1:0] chr_raw;
  logic [MW-1:0] prg_off;
  logic [MW-1:0] chr_off;
  logic          nt_phys;
  logic [MW-1:0] nt_off;
  logic          upper;
  logic          in_ram;

  always_comb begin
    // saturate the size registers into the supported range
    if (state.prg_log2 < mmc1m_pkg::PRG_LOG2_MIN)      prg_c = mmc1m_pkg::PRG_LOG2_MIN;
    else if (state.prg_log2 > mmc1m_pkg::PRG_LOG2_MAX) prg_c = mmc1m_pkg::PRG_LOG2_MAX;
    else                                               prg_c = state.prg_log2;
    if (state.chr_log2 < mmc1m_pkg::CHR_LOG2_MIN)      chr_c = mmc1m_pkg::CHR_LOG2_MIN;
    else if (state.chr_log2 > mmc1m_pkg::CHR_LOG2_MAX) chr_c = mmc1m_pkg::CHR_LOG2_MAX;
    else                                               chr_c = state.chr_log2;
  end

  assign prg_size = (MW+1)'(1) << prg_c;
  assign prg_mask = MW'(prg_size - (MW+1)'(1));
  assign prg_last = MW'(prg_size - (MW+1)'(16'h4000));
  assign chr_mask = MW'(((MW+1)'(1) << chr_c) - (MW+1)'(1));

  assign prg_mode = state.control[3:2];
  assign bank     = state.prg[3:0];
  assign upper    = addr[15] && addr[14];

  always_comb begin
    unique case (prg_mode)
      2'd0, 2'd1: prg_raw = {bank[3:1], addr[14:0]};
      2'd2:       prg_raw = upper ? {bank, addr[13:0]} : {4'd0, addr[13:0]};
      default:    prg_raw = upper ? (prg_last | {4'd0, addr[13:0]}) : {bank, addr[13:0]};
    endcase
  end
  assign prg_off = prg_raw & prg_mask;

  always_comb begin
    if (!state.control[4]) begin
      chr_raw = {1'b0, state.chr_lo[4:1], addr[12:0]};
    end else if (!addr[12]) begin
      chr_raw = {1'b0, state.chr_lo, addr[11:0]};
    end else begin
      chr_raw = {1'b0, state.chr_hi, addr[11:0]};
    end
  end
  assign chr_off = chr_raw & chr_mask;

  always_comb begin
    unique case (state.control[1:0])
      2'd0:    nt_phys = 1'b0;
      2'd1:    nt_phys = 1'b1;
      2'd2:    nt_phys = addr[10];
      default: nt_phys = addr[11];
    endcase
  end
  assign nt_off = {7'd0, nt_phys, addr[9:0]};

  assign in_ram = (addr[15:13] == 3'b011);

  always_comb begin
    result = '0;
    unique case (op)
      mmc1m_pkg::OP_PRG_RD: begin
        if (addr[15]) begin
          result.mapped_addr = prg_off;
          result.mem_enable  = 1'b1;
        end
      end
      mmc1m_pkg::OP_CHR_RD: begin
        result.mapped_addr = chr_off;
        result.mem_enable  = 1'b1;
      end
      mmc1m_pkg::OP_CHR_WR: begin
        result.mapped_addr = chr_off;
        result.mem_enable  = state.chr_is_ram;
      end
      mmc1m_pkg::OP_NT: begin
        result.mapped_addr = nt_off;
        result.mem_enable  = 1'b1;
      end
      mmc1m_pkg::OP_RAM_RD, mmc1m_pkg::OP_RAM_WR: begin
        if (in_ram) begin
          if (state.prg[4]) begin
            result.read_all_ones = (op == mmc1m_pkg::OP_RAM_RD);
          end else begin
            result.mapped_addr = {5'd0, addr[12:0]};
            result.mem_enable  = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> src/serial_bank_switch_mapper.sv
// Top level of the serial bank-switch mapper: input stage, output register, control.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------------------
//  s_       | in        | s_tvalid/s_tready  | tuser op; tdata addr, data
//  m_       | out       | m_tvalid/m_tready  | tdata mapped_addr, mem_enable, ones
//  cfg_     | in        | cfg_we             | cfg_index, cfg_data (no read-back)
//
// One access in, one result out, sustained one item per clock while m_ is not stalled.
// Each access passes the input register, then translation into the output register.
// Register loads update the bank registers as the item leaves the input register.
// A stall on m_ holds both stages; the input stage still takes a transfer while empty.
// Synchronous reset restores the bank and size registers at once; no clearing pass.
`default_nettype none
module serial_bank_switch_mapper (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [23:0]                          s_tdata,  // addr[15:0], data[23:16]
  input  wire logic [2:0]                           s_tuser,  // op[2:0]
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic [23:0]                               m_tdata,  // mapped_addr[17:0],
                                                              // mem_enable[18],
                                                              // read_all_ones[19], zero
  input  wire logic                                 cfg_we,
  input  wire logic [mmc1m_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mmc1m_pkg::CFG_W-1:0]          cfg_data
);

  logic                             in_valid;
  logic [2:0]                       in_op;
  logic [mmc1m_pkg::ADDR_W-1:0]     in_addr;
  logic [mmc1m_pkg::DATA_W-1:0]     in_data;
  logic                             advance;
  logic                             reg_wr;
  mmc1m_pkg::map_state_t            state;
  mmc1m_pkg::map_result_t           result;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign reg_wr   = advance && (in_op == mmc1m_pkg::OP_REG_WR);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= s_tuser;
      in_addr <= s_tdata[15:0];
      in_data <= s_tdata[23:16];
    end
  end

  mmc1m_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .reg_wr    (reg_wr),
    .addr      (in_addr),
    .data      (in_data),
    .state     (state)
  );

  mmc1m_xlate u_xlate (
    .op     (in_op),
    .addr   (in_addr),
    .state  (state),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {4'd0, result.read_all_ones, result.mem_enable, result.mapped_addr};
    end
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[18] && m_tdata[19]))
    else $error("memory enable and all-ones read raised together");

  a_refill: assert property (@(posedge clk) disable iff (rst)
    (in_valid && m_tvalid && m_tready) |=> m_tvalid)
    else $error("pending item did not move into the output register");

  a_reg_wr_quiet: assert property (@(posedge clk) disable iff (rst)
    reg_wr |=> (m_tdata[19:0] == 20'd0))
    else $error("register write produced a non-zero result");

endmodule
`default_nettype wire

>>> test/mapper_checker.sv
// Checker for the serial bank-switch mapper: predicts every translation and compares results.
`timescale 1ns / 100ps
module mapper_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  input  logic [23:0]                        s_tdata,   // addr[15:0], data[23:16]
  input  logic [2:0]                         s_tuser,   // op[2:0]
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic [23:0]                        m_tdata,   // mapped_addr[17:0], mem_enable[18],
                                                        // read_all_ones[19], zero
  input  logic                               cfg_we,
  input  logic [mmc1m_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mmc1m_pkg::CFG_W-1:0]        cfg_data,
  output int unsigned                        failures,
  output int unsigned                        outstanding
);

  // Shadow copy of the bank registers and size configuration
  logic [4:0] shadow_shift;
  logic [4:0] ctrl_reg;
  logic [4:0] chr_lo_reg;
  logic [4:0] chr_hi_reg;
  logic [4:0] prg_reg;
  logic [4:0] prg_log2;
  logic [4:0] chr_log2;
  logic       chr_ram;

  mmc1m_pkg::map_result_t expected_maps[$];

  initial begin
    failures    = 0;
    outstanding = 0;
  end

  function automatic logic [4:0] saturate(input logic [4:0] v, input logic [4:0] lo,
                                          input logic [4:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [17:0] prg_map(input logic [15:0] addr);
    logic [18:0] size;
    logic [18:0] mask;
    logic [18:0] r;
    logic [3:0]  bank;
    size = 19'd1 << saturate(prg_log2, mmc1m_pkg::PRG_LOG2_MIN, mmc1m_pkg::PRG_LOG2_MAX);
    mask = size - 19'd1;
    bank = prg_reg[3:0];
    case (ctrl_reg[3:2])
      2'd0, 2'd1: r = {1'b0, bank[3:1], addr[14:0]};
      2'd2: r = (addr < 16'hC000) ? {5'd0, addr[13:0]} : {1'b0, bank, addr[13:0]};
      default: r = (addr < 16'hC000) ? {1'b0, bank, addr[13:0]}
                                     : ((size - 19'h4000) | {5'd0, addr[13:0]});
    endcase
    return r[17:0] & mask[17:0];
  endfunction

  function automatic logic [17:0] chr_map(input logic [15:0] addr);
    logic [17:0] mask;
    logic [17:0] r;
    mask = (18'd1 << saturate(chr_log2, mmc1m_pkg::CHR_LOG2_MIN, mmc1m_pkg::CHR_LOG2_MAX))
           - 18'd1;
    if (!ctrl_reg[4])
      r = {1'b0, chr_lo_reg[4:1], addr[12:0]};
    else if (!addr[12])
      r = {1'b0, chr_lo_reg, addr[11:0]};
    else
      r = {1'b0, chr_hi_reg, addr[11:0]};
    return r & mask;
  endfunction

  function automatic logic [17:0] nametable_map(input logic [15:0] addr);
    logic phys;
    case (ctrl_reg[1:0])
      2'd0: phys = 1'b0;
      2'd1: phys = 1'b1;
      2'd2: phys = addr[10];
      default: phys = addr[11];
    endcase
    return {7'd0, phys, addr[9:0]};
  endfunction

  // Advance the shadow state by one bus access and give its translation
  task automatic translate_access(input logic [2:0] op, input logic [15:0] addr,
                                  input logic [7:0] data,
                                  output mmc1m_pkg::map_result_t res);
    logic       done;
    logic [4:0] value;
    res = '0;
    case (op)
      mmc1m_pkg::OP_REG_WR: begin
        if (addr[15]) begin
          if (data[7]) begin
            shadow_shift = mmc1m_pkg::SHIFT_RESET;
            ctrl_reg     = ctrl_reg | mmc1m_pkg::CTRL_RESET;
          end else begin
            done         = shadow_shift[0];
            shadow_shift = {data[0], shadow_shift[4:1]};
            if (done) begin
              value        = shadow_shift;
              shadow_shift = mmc1m_pkg::SHIFT_RESET;
              case (addr[14:13])
                2'd0: ctrl_reg   = value;
                2'd1: chr_lo_reg = value;
                2'd2: chr_hi_reg = value;
                default: prg_reg = value;
              endcase
            end
          end
        end
      end
      mmc1m_pkg::OP_PRG_RD: begin
        if (addr[15]) begin
          res.mapped_addr = prg_map(addr);
          res.mem_enable  = 1'b1;
        end
      end
      mmc1m_pkg::OP_CHR_RD: begin
        res.mapped_addr = chr_map(addr);
        res.mem_enable  = 1'b1;
      end
      mmc1m_pkg::OP_CHR_WR: begin
        res.mapped_addr = chr_map(addr);
        res.mem_enable  = chr_ram;
      end
      mmc1m_pkg::OP_NT: begin
        res.mapped_addr = nametable_map(addr);
        res.mem_enable  = 1'b1;
      end
      mmc1m_pkg::OP_RAM_RD, mmc1m_pkg::OP_RAM_WR: begin
        if (addr[15:13] == 3'b011) begin
          if (prg_reg[4]) begin
            res.read_all_ones = (op == mmc1m_pkg::OP_RAM_RD);
          end else begin
            res.mapped_addr = {5'd0, addr[12:0]};
            res.mem_enable  = 1'b1;
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : monitor
    mmc1m_pkg::map_result_t want;
    mmc1m_pkg::map_result_t got;
    if (rst) begin
      shadow_shift = mmc1m_pkg::SHIFT_RESET;
      ctrl_reg     = mmc1m_pkg::CTRL_RESET;
      chr_lo_reg   = '0;
      chr_hi_reg   = '0;
      prg_reg      = '0;
      prg_log2     = mmc1m_pkg::PRG_LOG2_RESET;
      chr_log2     = mmc1m_pkg::CHR_LOG2_RESET;
      chr_ram      = 1'b1;
      expected_maps.delete();
    end else begin
      // Compare before pushing, so a result never meets the access taken at the same edge
      if (m_tvalid && m_tready) begin
        got = m_tdata[19:0];
        if (expected_maps.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected result: addr %h en %b ones %b",
                     got.mapped_addr, got.mem_enable, got.read_all_ones);
        end else begin
          want = expected_maps.pop_front();
          if (got.mapped_addr !== want.mapped_addr || got.mem_enable !== want.mem_enable ||
              got.read_all_ones !== want.read_all_ones) begin
            failures++;
            if (failures <= 10)
              $display("mismatch: expected addr %h en %b ones %b, got addr %h en %b ones %b",
                       want.mapped_addr, want.mem_enable, want.read_all_ones,
                       got.mapped_addr, got.mem_enable, got.read_all_ones);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          mmc1m_pkg::CFG_PRG_LOG2: prg_log2 = cfg_data;
          mmc1m_pkg::CFG_CHR_LOG2: chr_log2 = cfg_data;
          mmc1m_pkg::CFG_CHR_RAM:  chr_ram  = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        translate_access(s_tuser, s_tdata[15:0], s_tdata[23:16], want);
        expected_maps.push_back(want);
      end
    end
    outstanding = expected_maps.size();
  end

endmodule

>>> test/testbench.sv
// Stimulus and verdict for the serial bank-switch mapper, checked by mapper_checker.
`timescale 1ns / 100ps
module testbench;

  localparam logic [2:0] OP_UNUSED   = 3'd7;
  localparam int         STALL_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [mmc1m_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mmc1m_pkg::CFG_W-1:0]     cfg_data = '0;

  int unsigned failures;
  int unsigned outstanding;
  int          send_idle = 0;
  int          recv_stall = 0;
  int          quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  serial_bank_switch_mapper u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mapper_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .failures(failures), .outstanding(outstanding)
  );

  always @(posedge clk)
    m_tready <= ($urandom_range(99) >= recv_stall);

  // Abort when neither channel has moved a transfer for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // Called just after a rising edge; returns at the edge of the transfer
  task automatic send(input logic [2:0] op, input logic [15:0] addr, input logic [7:0] data);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {data, addr};
    do @(posedge clk); while (!s_tready);
  endtask

  // Five serial writes; the address of the last one picks the register
  task automatic load_bank_reg(input logic [1:0] sel, input logic [4:0] value);
    logic [15:0] addr;
    for (int i = 0; i < 5; i++) begin
      addr = {1'b1, 15'($urandom)};
      if (i == 4)
        addr[14:13] = sel;
      send(mmc1m_pkg::OP_REG_WR, addr, {1'b0, 6'($urandom), value[i]});
    end
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    @(posedge clk);
  endtask

  task automatic write_config(input logic [4:0] prg_lg, input logic [4:0] chr_lg,
                              input logic ram);
    cfg_we    <= 1'b1;
    cfg_index <= mmc1m_pkg::CFG_PRG_LOG2;
    cfg_data  <= prg_lg;
    @(posedge clk);
    cfg_index <= mmc1m_pkg::CFG_CHR_LOG2;
    cfg_data  <= chr_lg;
    @(posedge clk);
    cfg_index <= mmc1m_pkg::CFG_CHR_RAM;
    cfg_data  <= {4'd0, ram};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_phase(input int phase);
    case (phase)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 78; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 78; end
      default: begin send_idle = 26; recv_stall = 26; end
    endcase
  endtask

  task automatic run_random(input int target);
    int             count;
    int             pick;
    mmc1m_pkg::op_t op;
    logic [15:0]    addr;
    count = 0;
    while (count < target) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        load_bank_reg(2'($urandom), 5'($urandom));
        count += 5;
      end else if (pick < 28) begin
        send(mmc1m_pkg::OP_REG_WR, {1'b1, 15'($urandom)}, {1'b1, 7'($urandom)});
        count++;
      end else if (pick < 31) begin
        // noise on the register port, including stray low addresses
        send(mmc1m_pkg::OP_REG_WR, 16'($urandom), 8'($urandom));
      end else if (pick < 33) begin
        send(OP_UNUSED, 16'($urandom), 8'($urandom));
      end else begin
        op   = mmc1m_pkg::op_t'($urandom_range(mmc1m_pkg::OP_PRG_RD, mmc1m_pkg::OP_RAM_WR));
        addr = 16'($urandom);
        if ($urandom_range(99) < 80) begin
          if (op == mmc1m_pkg::OP_PRG_RD)
            addr[15] = 1'b1;
          else if (op == mmc1m_pkg::OP_RAM_RD || op == mmc1m_pkg::OP_RAM_WR)
            addr[15:13] = 3'b011;
        end
        send(op, addr, 8'($urandom));
        count++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    set_phase(0);

    // Directed part at the reset configuration
    send(mmc1m_pkg::OP_PRG_RD, 16'h8000, 8'h00);
    send(mmc1m_pkg::OP_PRG_RD, 16'hFFFF, 8'hFF);
    send(mmc1m_pkg::OP_PRG_RD, 16'h7FFF, 8'h00);
    send(mmc1m_pkg::OP_CHR_RD, 16'hFFFF, 8'h00);
    send(mmc1m_pkg::OP_CHR_WR, 16'h0000, 8'hFF);
    send(mmc1m_pkg::OP_NT, 16'h2C00, 8'h00);
    send(mmc1m_pkg::OP_NT, 16'hFFFF, 8'h00);
    send(mmc1m_pkg::OP_RAM_RD, 16'h5FFF, 8'h00);
    send(mmc1m_pkg::OP_RAM_WR, 16'h7FFF, 8'hAA);
    send(OP_UNUSED, 16'hFFFF, 8'hFF);
    send(mmc1m_pkg::OP_REG_WR, 16'h7FFF, 8'h01);
    send(mmc1m_pkg::OP_REG_WR, 16'hFFFF, 8'h01);
    send(mmc1m_pkg::OP_REG_WR, 16'h8000, 8'h80);
    load_bank_reg(2'd3, 5'h10);         // disable work RAM
    send(mmc1m_pkg::OP_RAM_RD, 16'h6000, 8'h00);
    send(mmc1m_pkg::OP_RAM_WR, 16'h6000, 8'h55);
    load_bank_reg(2'd0, 5'h13);         // 4K pattern banks, 32K program, nametable picked by address bit 11
    send(mmc1m_pkg::OP_CHR_RD, 16'h1000, 8'h00);
    send(mmc1m_pkg::OP_PRG_RD, 16'hC000, 8'h00);

    for (int seg = 0; seg < 8; seg++) begin
      settle();
      case (seg)
        0: write_config(mmc1m_pkg::PRG_LOG2_MIN, mmc1m_pkg::CHR_LOG2_MIN, 1'b0);
        1: write_config(mmc1m_pkg::PRG_LOG2_MAX, mmc1m_pkg::CHR_LOG2_MAX, 1'b1);
        2: write_config(5'd0, 5'd0, 1'b0);
        3: write_config(5'd31, 5'd31, 1'b1);
        default: write_config(5'($urandom_range(12, 20)), 5'($urandom_range(11, 19)),
                              1'($urandom));
      endcase
      set_phase(seg % 4);
      run_random(100);
    end

    settle();
    repeat (10) @(posedge clk);
    if (failures == 0 && outstanding == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
